>>> sv/cblacs_pkg.sv
// ----------------------------------------------------------------------------
// cblacs_pkg
// shared types and constants for the conditional branch / load-store / alu
// step core
// ----------------------------------------------------------------------------
package cblacs_pkg;

    localparam int unsigned XLEN      = 32;
    localparam int unsigned REG_COUNT = 16;
    localparam int unsigned REG_AW    = 4;

    localparam logic [REG_AW-1:0] REG_LINK = 4'hE;
    localparam logic [REG_AW-1:0] REG_PC   = 4'hF;

    localparam logic [XLEN-1:0] PC_STEP  = 32'h0000_0004;
    localparam logic [XLEN-1:0] PC_AHEAD = 32'h0000_0008;

    // instruction class masks and matches
    localparam logic [XLEN-1:0] BRANCH_MASK  = 32'h0E00_0000;
    localparam logic [XLEN-1:0] BRANCH_MATCH = 32'h0A00_0000;
    localparam logic [XLEN-1:0] LDST_MASK    = 32'h0C00_0000;
    localparam logic [XLEN-1:0] LDST_MATCH   = 32'h0400_0000;
    localparam logic [XLEN-1:0] ALU_MATCH    = 32'h0000_0000;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_READ  = 2'd1,
        MEM_WRITE = 2'd2
    } mem_req_t;

    typedef enum logic [3:0] {
        OP_SUB = 4'h2,
        OP_ADD = 4'h4,
        OP_CMP = 4'hA,
        OP_MOV = 4'hD
    } alu_op_t;

    typedef enum logic [3:0] {
        COND_EQ = 4'h0,
        COND_NE = 4'h1,
        COND_CS = 4'h2,
        COND_CC = 4'h3,
        COND_MI = 4'h4,
        COND_PL = 4'h5,
        COND_VS = 4'h6,
        COND_VC = 4'h7,
        COND_HI = 4'h8,
        COND_LS = 4'h9,
        COND_GE = 4'hA,
        COND_LT = 4'hB,
        COND_GT = 4'hC,
        COND_LE = 4'hD,
        COND_AL = 4'hE,
        COND_NV = 4'hF
    } cond_t;

    typedef struct packed {
        logic            kind;
        logic [XLEN-1:0] instruction_word;
        logic [XLEN-1:0] load_data;
    } item_t;

    typedef struct packed {
        logic [1:0]      mem_request;
        logic [XLEN-1:0] mem_address;
        logic [XLEN-1:0] mem_write_data;
        logic [XLEN-1:0] next_fetch_address;
        logic            condition_passed;
        logic [3:0]      flags_nzcv;
    } result_t;

    // register file write port
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } reg_wr_t;

    // architectural state update from the execute logic
    typedef struct packed {
        reg_wr_t           wr;
        logic [XLEN-1:0]   pc;
        logic [3:0]        flags;
        logic              pending;
        logic [REG_AW-1:0] target;
    } state_upd_t;

endpackage

>>> sv/cond_branch_ldst_alu_core_step.sv
// ----------------------------------------------------------------------------
// cond_branch_ldst_alu_core_step
// one-step interpreter for a reduced 32-bit instruction subset: condition
// test, branch / branch-with-link, word load/store, mov/add/sub/cmp
// ----------------------------------------------------------------------------
//
//  channel   handshake                  word     carries
//  --------  -------------------------  -------  ------------------------------
//  item      item_valid/item_stall      item     fetched instruction or load data
//  result    result_valid/result_stall  result   memory request, next pc, flags
//
// - one word per cycle sustained while result_stall is low; a taken word is
//   held in the input register, then executes into the result register
// - state (pc, flags, load tracking) updates as a word leaves the input
//   register, so the next word executes against it with no gap
// - general registers read zero after reset through per-entry valid bits;
//   no clearing pass, the block takes words from the first cycle
// - item_stall rises only when the input register is full and the result
//   register is held by result_stall
//
module cond_branch_ldst_alu_core_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  cblacs_pkg::item_t    item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output cblacs_pkg::result_t  result
);

    // input register
    logic                          in_valid_reg;
    logic                          in_valid_next;
    cblacs_pkg::item_t             in_word_reg;

    // result register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    cblacs_pkg::result_t           out_word_reg;

    // architectural state, pc held outside the register store
    logic [cblacs_pkg::XLEN-1:0]   pc_reg;
    logic [3:0]                    flags_reg;
    logic                          pend_reg;
    logic [cblacs_pkg::REG_AW-1:0] target_reg;

    logic                          accept;
    logic                          advance;
    logic                          fire;
    logic [cblacs_pkg::XLEN-1:0]   rn_data;
    logic [cblacs_pkg::XLEN-1:0]   rd_data;
    cblacs_pkg::result_t           exec_result;
    cblacs_pkg::state_upd_t        upd;
    cblacs_pkg::reg_wr_t           reg_wr;

    // result register frees when empty or when its word is taken
    assign advance    = !out_valid_reg || !result_stall;
    assign fire       = in_valid_reg && advance;
    assign item_stall = in_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg <= item;
        end
        if (fire)
        begin
            out_word_reg <= exec_result;
        end
    end

    // architectural state commits as the word executes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= '0;
            flags_reg  <= '0;
            pend_reg   <= 1'b0;
            target_reg <= '0;
        end
        else if (fire)
        begin
            pc_reg     <= upd.pc;
            flags_reg  <= upd.flags;
            pend_reg   <= upd.pending;
            target_reg <= upd.target;
        end
    end

    // register store writes only on the executing word
    always_comb
    begin
        reg_wr    = upd.wr;
        reg_wr.en = upd.wr.en && fire;
    end

    // operands are read as the word enters, base from bits 19:16 and
    // store data / destination from bits 15:12
    cblacs_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (reg_wr),
        .rd_en     (accept),
        .rd_addr_a (item.instruction_word[19:16]),
        .rd_addr_b (item.instruction_word[15:12]),
        .rd_data_a (rn_data),
        .rd_data_b (rd_data)
    );

    cblacs_exec u_exec (
        .item    (in_word_reg),
        .pc      (pc_reg),
        .flags   (flags_reg),
        .pending (pend_reg),
        .target  (target_reg),
        .rn_data (rn_data),
        .rd_data (rd_data),
        .result  (exec_result),
        .upd     (upd)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    // an executing word always lands in the result register
    a_fire_lands : assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> result_valid)
        else $error("executed word did not reach the result register");

    // fetches while a load is outstanding do nothing
    a_pending_fetch_ignored : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && pend_reg && !in_word_reg.kind)
        |=> (!result.condition_passed
             && (result.mem_request == cblacs_pkg::MEM_NONE)
             && pend_reg))
        else $error("fetch during outstanding load was not ignored");

    // a read request leaves a load outstanding
    a_read_sets_pending : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (exec_result.mem_request == cblacs_pkg::MEM_READ)) |=> pend_reg)
        else $error("read request without outstanding load");

    // carry and overflow are never produced
    a_cv_clear : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.flags_nzcv[1:0] == 2'b00))
        else $error("carry or overflow flag set");

    // a held result keeps the word in the input register
    a_hold_input : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && result_valid && result_stall) |=> in_valid_reg)
        else $error("input word lost while result stalled");

endmodule

>>> sv/cblacs_regfile.sv
// ----------------------------------------------------------------------------
// cblacs_regfile
// general register store, one write port and two registered read ports with
// write-first bypass; entries read as zero until first written
// ----------------------------------------------------------------------------
module cblacs_regfile (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cblacs_pkg::reg_wr_t             wr,
    input  logic                            rd_en,
    input  logic [cblacs_pkg::REG_AW-1:0]   rd_addr_a,
    input  logic [cblacs_pkg::REG_AW-1:0]   rd_addr_b,
    output logic [cblacs_pkg::XLEN-1:0]     rd_data_a,
    output logic [cblacs_pkg::XLEN-1:0]     rd_data_b
);

    logic [cblacs_pkg::XLEN-1:0]      mem [cblacs_pkg::REG_COUNT];
    logic [cblacs_pkg::REG_COUNT-1:0] valid_reg;
    logic [cblacs_pkg::XLEN-1:0]      rd_data_a_reg;
    logic [cblacs_pkg::XLEN-1:0]      rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // write-first so a reader never sees the value just overwritten
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.en && (wr.addr == rd_addr_a))
            begin
                rd_data_a_reg <= wr.data;
            end
            else
            begin
                rd_data_a_reg <= valid_reg[rd_addr_a] ? mem[rd_addr_a] : '0;
            end
            if (wr.en && (wr.addr == rd_addr_b))
            begin
                rd_data_b_reg <= wr.data;
            end
            else
            begin
                rd_data_b_reg <= valid_reg[rd_addr_b] ? mem[rd_addr_b] : '0;
            end
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

>>> sv/cblacs_exec.sv
// ----------------------------------------------------------------------------
// cblacs_exec
// single-pass execute: condition test, decode, address / alu adder and
// next architectural state for one word
// ----------------------------------------------------------------------------
module cblacs_exec (
    input  cblacs_pkg::item_t                item,
    input  logic [cblacs_pkg::XLEN-1:0]      pc,
    input  logic [3:0]                       flags,
    input  logic                             pending,
    input  logic [cblacs_pkg::REG_AW-1:0]    target,
    input  logic [cblacs_pkg::XLEN-1:0]      rn_data,
    input  logic [cblacs_pkg::XLEN-1:0]      rd_data,
    output cblacs_pkg::result_t              result,
    output cblacs_pkg::state_upd_t           upd
);

    logic                           n_f;
    logic                           z_f;
    logic                           c_f;
    logic                           v_f;
    logic                           cond_ok;
    logic [cblacs_pkg::XLEN-1:0]    insn;
    logic [cblacs_pkg::REG_AW-1:0]  rn;
    logic [cblacs_pkg::REG_AW-1:0]  rd;
    logic [cblacs_pkg::XLEN-1:0]    imm;
    logic [cblacs_pkg::XLEN-1:0]    rn_val;
    logic [cblacs_pkg::XLEN-1:0]    rd_val;
    logic [cblacs_pkg::XLEN-1:0]    offset;
    logic [cblacs_pkg::XLEN-1:0]    diff;

    assign insn   = item.instruction_word;
    assign rn     = insn[19:16];
    assign rd     = insn[15:12];
    assign imm    = {20'd0, insn[11:0]};
    assign offset = {{6{insn[23]}}, insn[23:0], 2'b00};
    assign n_f    = flags[3];
    assign z_f    = flags[2];
    assign c_f    = flags[1];
    assign v_f    = flags[0];

    // register 15 reads as the current instruction address
    assign rn_val = (rn == cblacs_pkg::REG_PC) ? pc : rn_data;
    assign rd_val = (rd == cblacs_pkg::REG_PC) ? pc : rd_data;
    assign diff   = rn_val - imm;

    always_comb
    begin
        unique case (cblacs_pkg::cond_t'(insn[31:28]))
            cblacs_pkg::COND_EQ: cond_ok = z_f;
            cblacs_pkg::COND_NE: cond_ok = !z_f;
            cblacs_pkg::COND_CS: cond_ok = c_f;
            cblacs_pkg::COND_CC: cond_ok = !c_f;
            cblacs_pkg::COND_MI: cond_ok = n_f;
            cblacs_pkg::COND_PL: cond_ok = !n_f;
            cblacs_pkg::COND_VS: cond_ok = v_f;
            cblacs_pkg::COND_VC: cond_ok = !v_f;
            cblacs_pkg::COND_HI: cond_ok = c_f && !z_f;
            cblacs_pkg::COND_LS: cond_ok = !c_f || z_f;
            cblacs_pkg::COND_GE: cond_ok = (n_f == v_f);
            cblacs_pkg::COND_LT: cond_ok = (n_f != v_f);
            cblacs_pkg::COND_GT: cond_ok = !z_f && (n_f == v_f);
            cblacs_pkg::COND_LE: cond_ok = z_f || (n_f != v_f);
            cblacs_pkg::COND_AL: cond_ok = 1'b1;
            cblacs_pkg::COND_NV: cond_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        logic [cblacs_pkg::XLEN-1:0] alu_res;
        logic                        alu_wr;

        alu_res               = '0;
        alu_wr                = 1'b0;
        result                = '0;
        result.mem_request    = cblacs_pkg::MEM_NONE;
        upd.wr                = '0;
        upd.pc                = pc;
        upd.flags             = flags;
        upd.pending           = pending;
        upd.target            = target;

        if (item.kind)
        begin
            // load return, dropped when nothing is outstanding
            if (pending)
            begin
                upd.pending = 1'b0;
                if (target == cblacs_pkg::REG_PC)
                begin
                    upd.pc = item.load_data;
                end
                else
                begin
                    upd.wr.en   = 1'b1;
                    upd.wr.addr = target;
                    upd.wr.data = item.load_data;
                end
            end
        end
        else if (!pending)
        begin
            upd.pc = pc + cblacs_pkg::PC_STEP;
            if (cond_ok)
            begin
                result.condition_passed = 1'b1;
                if ((insn & cblacs_pkg::BRANCH_MASK) == cblacs_pkg::BRANCH_MATCH)
                begin
                    if (insn[24])
                    begin
                        upd.wr.en   = 1'b1;
                        upd.wr.addr = cblacs_pkg::REG_LINK;
                        upd.wr.data = pc + cblacs_pkg::PC_STEP;
                    end
                    upd.pc = pc + cblacs_pkg::PC_AHEAD + offset;
                end
                else if ((insn & cblacs_pkg::LDST_MASK) == cblacs_pkg::LDST_MATCH)
                begin
                    result.mem_address = rn_val + imm;
                    if (insn[20])
                    begin
                        result.mem_request = cblacs_pkg::MEM_READ;
                        upd.pending        = 1'b1;
                        upd.target         = rd;
                    end
                    else
                    begin
                        result.mem_request    = cblacs_pkg::MEM_WRITE;
                        result.mem_write_data = rd_val;
                    end
                end
                else if ((insn & cblacs_pkg::LDST_MASK) == cblacs_pkg::ALU_MATCH)
                begin
                    unique case (cblacs_pkg::alu_op_t'(insn[24:21]))
                        cblacs_pkg::OP_MOV:
                        begin
                            alu_res = imm;
                            alu_wr  = 1'b1;
                        end
                        cblacs_pkg::OP_ADD:
                        begin
                            alu_res = rn_val + imm;
                            alu_wr  = 1'b1;
                        end
                        cblacs_pkg::OP_SUB:
                        begin
                            alu_res = diff;
                            alu_wr  = 1'b1;
                        end
                        cblacs_pkg::OP_CMP:
                        begin
                            upd.flags = {diff[31], (diff == '0), flags[1:0]};
                        end
                        default:
                        begin
                            alu_wr = 1'b0;
                        end
                    endcase
                    if (alu_wr)
                    begin
                        if (rd == cblacs_pkg::REG_PC)
                        begin
                            upd.pc = alu_res;
                        end
                        else
                        begin
                            upd.wr.en   = 1'b1;
                            upd.wr.addr = rd;
                            upd.wr.data = alu_res;
                        end
                    end
                end
            end
        end

        result.next_fetch_address = upd.pc;
        result.flags_nzcv         = upd.flags;
    end

endmodule
